// ===== design/ncm_pkg.sv =====
// Package for the nixie crossfade multiplexer: item structs, command word,
// fade ramp table and default sizes. No dependencies.
`default_nettype none

package ncm_pkg;

  // Default sizes handed to the top level
  localparam int unsigned TUBE_COUNT_DEF = 6;
  localparam int unsigned FADE_STEPS_DEF = 128;

  // Queue depths between the parts
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 4;

  // Tube index in a command, wide enough for sixteen tubes
  localparam int unsigned TUBE_IDX_W = 4;

  // Fixed constants of the data path
  localparam logic [5:0] FULL_TIME   = 6'h3F;
  localparam logic [3:0] BLANK_RESET = 4'hF;
  localparam logic [4:0] VALUE_RESET = 5'h0F;
  localparam int unsigned FLASH_BIT  = 4;
  localparam int unsigned TABLE_LEN  = 128;

  // Operation codes of an input transaction
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SLOT  = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [2:0] digit;
    logic [4:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0] tube_code;
    logic [2:0] anode;
    logic [5:0] on_time;
    logic       last;
  } out_item_t;

  // Classified command passed from the front to the engine
  typedef struct packed {
    logic                  is_slot;
    logic [TUBE_IDX_W-1:0] tube;
    logic [4:0]            value;
  } cmd_t;

  // Brightness ramp, full on down to dark
  localparam logic [5:0] RAMP [TABLE_LEN] = '{
    6'h3F, 6'h3E, 6'h3E, 6'h3E, 6'h3E, 6'h3E, 6'h3E, 6'h3E,
    6'h3E, 6'h3E, 6'h3D, 6'h3D, 6'h3D, 6'h3D, 6'h3D, 6'h3D, 6'h3D, 6'h3D,
    6'h3D, 6'h3C, 6'h3C, 6'h3C, 6'h3C, 6'h3C, 6'h3C, 6'h3C, 6'h3C, 6'h3B,
    6'h3B, 6'h3B, 6'h3B, 6'h3B, 6'h3B, 6'h3B, 6'h3A, 6'h3A, 6'h3A, 6'h3A,
    6'h3A, 6'h3A, 6'h3A, 6'h39, 6'h39, 6'h39, 6'h39, 6'h39, 6'h39, 6'h39,
    6'h38, 6'h38, 6'h38, 6'h38, 6'h38, 6'h38, 6'h37, 6'h37, 6'h37, 6'h37,
    6'h37, 6'h36, 6'h36, 6'h36, 6'h36, 6'h36, 6'h36, 6'h35, 6'h35, 6'h35,
    6'h35, 6'h34, 6'h34, 6'h34, 6'h34, 6'h34, 6'h33, 6'h33, 6'h33, 6'h33,
    6'h32, 6'h32, 6'h32, 6'h31, 6'h31, 6'h31, 6'h31, 6'h30, 6'h30, 6'h30,
    6'h2F, 6'h2F, 6'h2F, 6'h2E, 6'h2E, 6'h2E, 6'h2D, 6'h2D, 6'h2D, 6'h2C,
    6'h2C, 6'h2B, 6'h2B, 6'h2A, 6'h2A, 6'h29, 6'h29, 6'h28, 6'h28, 6'h27,
    6'h26, 6'h26, 6'h25, 6'h24, 6'h24, 6'h23, 6'h22, 6'h21, 6'h20, 6'h1F,
    6'h1D, 6'h1C, 6'h1B, 6'h19, 6'h17, 6'h14, 6'h12, 6'h0E, 6'h09, 6'h00
  };

endpackage

`default_nettype wire

// ===== design/ncm_fifo.sv =====
// Small register FIFO used for the command queue and the result queue.
// Depends on ncm_pkg for default sizes.
`default_nettype none

module ncm_fifo #(
  parameter int unsigned WIDTH = $bits(ncm_pkg::cmd_t),
  parameter int unsigned DEPTH = ncm_pkg::CMD_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic                  full_o,
  input  wire logic             rd_i,
  output logic      [WIDTH-1:0] rd_data_o,
  output logic                  empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/ncm_front.sv =====
// Front end: accepts input transactions, classifies them into commands and
// queues them for the engine. Depends on ncm_pkg and ncm_fifo.
`default_nettype none

module ncm_front #(
  parameter int unsigned TUBE_COUNT = ncm_pkg::TUBE_COUNT_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ncm_pkg::in_item_t item_i,
  output logic                  full_o,
  input  wire logic             cmd_pop_i,
  output ncm_pkg::cmd_t         cmd_o,
  output logic                  cmd_valid_o
);

  ncm_pkg::cmd_t cmd_in;
  logic          in_range;
  logic          keep;
  logic          cmd_empty;

  // Writes are addressed from the far end; out-of-range ones are dropped here
  assign in_range       = ({2'b00, item_i.digit} < 5'(TUBE_COUNT));
  assign keep           = (item_i.operation == ncm_pkg::OP_SLOT) || in_range;
  assign cmd_in.is_slot = (item_i.operation == ncm_pkg::OP_SLOT);
  assign cmd_in.tube    = ncm_pkg::TUBE_IDX_W'(TUBE_COUNT - 1)
                          - {1'b0, item_i.digit};
  assign cmd_in.value   = item_i.value;

  ncm_fifo #(
    .WIDTH ($bits(ncm_pkg::cmd_t)),
    .DEPTH (ncm_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push_i && keep),
    .wr_data_i (cmd_in),
    .full_o    (full_o),
    .rd_i      (cmd_pop_i),
    .rd_data_o (cmd_o),
    .empty_o   (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

`default_nettype wire

// ===== design/ncm_engine.sv =====
// Back end: per-tube fade state, slot rotation and segment generation.
// Holds the blank code register. Depends on ncm_pkg.
`default_nettype none

module ncm_engine #(
  parameter int unsigned TUBE_COUNT = ncm_pkg::TUBE_COUNT_DEF,
  parameter int unsigned FADE_STEPS = ncm_pkg::FADE_STEPS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [3:0]    cfg_wdata_i,
  input  wire ncm_pkg::cmd_t cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_pop_o,
  input  wire logic          seg_full_i,
  output logic               seg_push_o,
  output ncm_pkg::out_item_t seg_o
);

  localparam int unsigned SW   = (TUBE_COUNT > 1) ? $clog2(TUBE_COUNT) : 1;
  localparam int unsigned PW   = $clog2(FADE_STEPS);
  localparam int unsigned LAST = FADE_STEPS - 1;

  localparam logic [1:0] PH_STEADY = 2'd0;
  localparam logic [1:0] PH_CROSS  = 2'd1;
  localparam logic [1:0] PH_OUT    = 2'd2;
  localparam logic [1:0] PH_IN     = 2'd3;

  logic [3:0]    blank_q;
  logic [SW-1:0] slot_q, slot_d;
  logic [1:0]    phase_q  [TUBE_COUNT];
  logic [4:0]    shown_q  [TUBE_COUNT];
  logic [4:0]    target_q [TUBE_COUNT];
  logic [4:0]    req_q    [TUBE_COUNT];
  logic [PW-1:0] pos_q    [TUBE_COUNT];

  logic                pend_q;
  ncm_pkg::out_item_t  pend_seg_q;

  // Ramp scaled onto the fade length, built at elaboration
  logic [5:0] step_lut [FADE_STEPS];
  for (genvar g = 0; g < FADE_STEPS; g++) begin : g_step
    assign step_lut[g] = ncm_pkg::RAMP[(g * (ncm_pkg::TABLE_LEN - 1)) / LAST];
  end

  logic               exec_slot, exec_write;
  logic [SW-1:0]      wr_idx;
  logic [1:0]         ph, ph_n;
  logic [4:0]         sh, sh_n, tg, tg_n, rq;
  logic [PW-1:0]      pos, pos_n, p;
  logic [5:0]         d;
  logic               two_segs;
  logic [SW+2:0]      slot_ext;
  ncm_pkg::out_item_t seg0, seg1;

  // Handshake with the command queue and the result queue
  assign cmd_pop_o  = !pend_q && cmd_valid_i && (!cmd_i.is_slot || !seg_full_i);
  assign exec_slot  = cmd_pop_o && cmd_i.is_slot;
  assign exec_write = cmd_pop_o && !cmd_i.is_slot;
  assign seg_push_o = pend_q ? !seg_full_i : exec_slot;
  assign seg_o      = pend_q ? pend_seg_q : seg0;
  assign wr_idx     = cmd_i.tube[SW-1:0];

  // Current tube record
  assign ph       = phase_q[slot_q];
  assign sh       = shown_q[slot_q];
  assign tg       = target_q[slot_q];
  assign rq       = req_q[slot_q];
  assign pos      = pos_q[slot_q];
  assign slot_ext = (SW + 3)'(slot_q);
  assign slot_d   = (slot_q == SW'(TUBE_COUNT - 1)) ? '0 : slot_q + SW'(1);

  // Fade step: saturate, look up
  assign p = (pos > PW'(LAST)) ? PW'(LAST) : pos;
  assign d = step_lut[p];

  // Phase machine and segment formation for one slot
  always_comb begin
    ph_n     = ph;
    sh_n     = sh;
    tg_n     = tg;
    pos_n    = p + PW'(1);
    two_segs = 1'b1;
    seg0     = '{tube_code: sh[3:0], anode: slot_ext[2:0], on_time: d, last: 1'b0};
    seg1     = '{tube_code: blank_q, anode: slot_ext[2:0],
                 on_time: ncm_pkg::FULL_TIME - d, last: 1'b1};
    unique case (ph)
      PH_STEADY: begin
        pos_n    = pos;
        two_segs = 1'b0;
        if (tg != rq) begin
          tg_n  = rq;
          ph_n  = rq[ncm_pkg::FLASH_BIT] ? PH_OUT : PH_CROSS;
          pos_n = '0;
        end
        seg0.on_time = ncm_pkg::FULL_TIME;
        seg0.last    = 1'b1;
      end
      PH_CROSS: begin
        if (d == '0) begin
          sh_n  = tg;
          ph_n  = PH_STEADY;
          pos_n = '0;
        end
        seg0.tube_code = sh_n[3:0];
        seg1.tube_code = tg[3:0];
      end
      PH_OUT: begin
        if (d == '0) begin
          ph_n  = PH_IN;
          sh_n  = tg;
          pos_n = '0;
        end
      end
      default: begin
        if (d == '0) begin
          ph_n  = (sh != tg) ? PH_CROSS : PH_OUT;
          pos_n = '0;
        end
      end
    endcase
    // Flash phases blank the whole slot when the ramp runs out
    if (ph != PH_STEADY && ph != PH_CROSS && d == '0) begin
      two_segs       = 1'b0;
      seg0.tube_code = blank_q;
      seg0.on_time   = ncm_pkg::FULL_TIME;
      seg0.last      = 1'b1;
    end
  end

  // Blank code register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q <= ncm_pkg::BLANK_RESET;
    end else if (cfg_we_i) begin
      blank_q <= cfg_wdata_i;
    end
  end

  // Tube records, rotation and second-segment hold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      pend_q <= 1'b0;
      for (int i = 0; i < TUBE_COUNT; i++) begin
        phase_q[i]  <= PH_STEADY;
        shown_q[i]  <= ncm_pkg::VALUE_RESET;
        target_q[i] <= ncm_pkg::VALUE_RESET;
        req_q[i]    <= ncm_pkg::VALUE_RESET;
        pos_q[i]    <= '0;
      end
    end else begin
      if (pend_q && !seg_full_i) begin
        pend_q <= 1'b0;
      end
      if (exec_write) begin
        req_q[wr_idx] <= cmd_i.value;
      end
      if (exec_slot) begin
        slot_q           <= slot_d;
        phase_q[slot_q]  <= ph_n;
        shown_q[slot_q]  <= sh_n;
        target_q[slot_q] <= tg_n;
        pos_q[slot_q]    <= pos_n;
        pend_q           <= two_segs;
      end
    end
  end

  // Second segment payload
  always_ff @(posedge clk_i) begin
    if (exec_slot) begin
      pend_seg_q <= seg1;
    end
  end

endmodule

`default_nettype wire

// ===== design/nixie_crossfade_multiplexer_core.sv =====
// Top level of the nixie crossfade multiplexer: front end, engine and result
// queue. Depends on ncm_pkg, ncm_front, ncm_engine and ncm_fifo.
`default_nettype none

// Drives a row of multiplexed nixie tubes with crossfading and flashing.
// A write transaction (operation 0) stores a requested value for a tube,
// addressed from the far end; bit 4 of the value asks for flashing. A slot
// transaction (operation 1) serves the next tube in rotation and yields one
// or two segments (code, anode, on-time out of 63, last flag) on the result
// queue. Transactions pass through a two-entry command queue to the engine,
// which takes a write even while the result queue is full and hands the
// segments of a slot to the result queue one segment a cycle while that
// queue is not full; it takes no new transaction while a second segment
// waits. The blank code register may be written at any cycle while no
// transaction is in flight; it takes effect on the next slot.
module nixie_crossfade_multiplexer_core #(
  parameter int unsigned TUBE_COUNT = ncm_pkg::TUBE_COUNT_DEF,
  parameter int unsigned FADE_STEPS = ncm_pkg::FADE_STEPS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  input  wire ncm_pkg::in_item_t in_item_i,
  output logic                   full,
  output logic                   empty,
  input  wire logic              pop,
  output ncm_pkg::out_item_t     out_item_o,
  input  wire logic              cfg_we_i,
  input  wire logic [3:0]        cfg_wdata_i
);

  ncm_pkg::cmd_t      cmd;
  logic               cmd_valid, cmd_pop;
  logic               seg_push, seg_full;
  ncm_pkg::out_item_t seg;

  ncm_front #(
    .TUBE_COUNT (TUBE_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid)
  );

  ncm_engine #(
    .TUBE_COUNT (TUBE_COUNT),
    .FADE_STEPS (FADE_STEPS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .seg_full_i  (seg_full),
    .seg_push_o  (seg_push),
    .seg_o       (seg)
  );

  // Result queue
  ncm_fifo #(
    .WIDTH ($bits(ncm_pkg::out_item_t)),
    .DEPTH (ncm_pkg::RES_DEPTH)
  ) u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (seg_push),
    .wr_data_i (seg),
    .full_o    (seg_full),
    .rd_i      (pop),
    .rd_data_o (out_item_o),
    .empty_o   (empty)
  );

endmodule

`default_nettype wire

// ===== design/ncm_checker.sv =====
// Port-level checks for the nixie crossfade multiplexer, bound to the top.
// Depends on ncm_pkg and nixie_crossfade_multiplexer_core.
`default_nettype none

module ncm_checker #(
  parameter int unsigned TUBE_COUNT = ncm_pkg::TUBE_COUNT_DEF
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               pop,
  input wire logic               empty,
  input wire ncm_pkg::out_item_t out_item_o
);

  // Nothing to deliver while in reset
  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result queue not empty during reset");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed or vanished");

  // Anode always names a fitted tube
  a_anode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (TUBE_COUNT > 8 || 32'(out_item_o.anode) < TUBE_COUNT))
    else $error("anode out of range");

  // The second segment of a slot follows straight after the first
  a_second_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !out_item_o.last) |=> !empty)
    else $error("second segment of slot missing");

  a_second_anode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !out_item_o.last) |=>
      (out_item_o.anode == $past(out_item_o.anode)))
    else $error("second segment of slot on another tube");

endmodule

bind nixie_crossfade_multiplexer_core ncm_checker #(
  .TUBE_COUNT (TUBE_COUNT)
) u_ncm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .pop        (pop),
  .empty      (empty),
  .out_item_o (out_item_o)
);

`default_nettype wire

// ===== tb/sv/nixie_crossfade_multiplexer_core_test.sv =====
// Self-checking testbench for nixie_crossfade_multiplexer_core: a segment
// scoreboard with its own tube-state predictor, queue-style drivers and checks.
// Depends on ncm_pkg and the core RTL only.
`timescale 1ns / 1ps

// Per-tube brightness phase as tracked by the predictor
typedef enum logic [1:0] {
  PH_STEADY   = 2'd0,
  PH_CROSS    = 2'd1,
  PH_FADE_OUT = 2'd2,
  PH_FADE_IN  = 2'd3
} tube_phase_e;

// Scoreboard: predicts the segments of each slot and checks them in order
class segment_board;
  localparam int unsigned TUBES = ncm_pkg::TUBE_COUNT_DEF;
  localparam int unsigned STEPS = ncm_pkg::FADE_STEPS_DEF;

  logic [3:0]  blank;
  int unsigned slot;
  tube_phase_e phase_q   [TUBES];
  logic [4:0]  shown     [TUBES];
  logic [4:0]  target    [TUBES];
  logic [4:0]  requested [TUBES];
  int unsigned fade_pos  [TUBES];

  ncm_pkg::out_item_t due_segments[$];
  int unsigned        seg_checked;
  int unsigned        seg_errors;

  function new();
    blank       = ncm_pkg::BLANK_RESET;
    slot        = 0;
    seg_checked = 0;
    seg_errors  = 0;
    for (int i = 0; i < TUBES; i++) begin
      phase_q[i]   = PH_STEADY;
      shown[i]     = ncm_pkg::VALUE_RESET;
      target[i]    = ncm_pkg::VALUE_RESET;
      requested[i] = ncm_pkg::VALUE_RESET;
      fade_pos[i]  = 0;
    end
  endfunction

  function int unsigned pending();
    return due_segments.size();
  endfunction

  // Next ramp value for a tube; position saturates on the last step
  function logic [5:0] fade_step(int unsigned t);
    int unsigned p;
    p = fade_pos[t];
    if (p > STEPS - 1) p = STEPS - 1;
    fade_pos[t] = p + 1;
    return ncm_pkg::RAMP[(p * (ncm_pkg::TABLE_LEN - 1) / (STEPS - 1))
                         % ncm_pkg::TABLE_LEN];
  endfunction

  function void add_segment(logic [3:0] code, int unsigned t, logic [5:0] on_t,
                            logic fin);
    ncm_pkg::out_item_t s;
    s.tube_code = code;
    s.anode     = 3'(t);
    s.on_time   = on_t;
    s.last      = fin;
    due_segments.push_back(s);
  endfunction

  // Accepted input transaction: update tube state, queue expected segments
  function void note_item(ncm_pkg::in_item_t it);
    int unsigned t;
    logic [5:0]  d;
    if (it.operation == ncm_pkg::OP_WRITE) begin
      // digits are counted from the far end; out-of-range ones are dropped
      if (it.digit < TUBES) requested[TUBES - 1 - it.digit] = it.value;
      return;
    end
    t    = (slot >= TUBES) ? 0 : slot;
    slot = (t + 1 >= TUBES) ? 0 : t + 1;
    case (phase_q[t])
      PH_STEADY: begin
        if (target[t] != requested[t]) begin
          target[t]   = requested[t];
          phase_q[t]  = requested[t][ncm_pkg::FLASH_BIT] ? PH_FADE_OUT : PH_CROSS;
          fade_pos[t] = 0;
        end
        add_segment(shown[t][3:0], t, ncm_pkg::FULL_TIME, 1'b1);
      end
      PH_CROSS: begin
        d = fade_step(t);
        if (d == 6'd0) begin
          shown[t]    = target[t];
          phase_q[t]  = PH_STEADY;
          fade_pos[t] = 0;
        end
        add_segment(shown[t][3:0], t, d, 1'b0);
        add_segment(target[t][3:0], t, ncm_pkg::FULL_TIME - d, 1'b1);
      end
      PH_FADE_OUT: begin
        d = fade_step(t);
        if (d == 6'd0) begin
          phase_q[t]  = PH_FADE_IN;
          shown[t]    = target[t];
          fade_pos[t] = 0;
          add_segment(blank, t, ncm_pkg::FULL_TIME, 1'b1);
        end else begin
          add_segment(shown[t][3:0], t, d, 1'b0);
          add_segment(blank, t, ncm_pkg::FULL_TIME - d, 1'b1);
        end
      end
      default: begin
        d = fade_step(t);
        if (d == 6'd0) begin
          phase_q[t]  = (shown[t] != target[t]) ? PH_CROSS : PH_FADE_OUT;
          fade_pos[t] = 0;
          add_segment(blank, t, ncm_pkg::FULL_TIME, 1'b1);
        end else begin
          add_segment(shown[t][3:0], t, d, 1'b0);
          add_segment(blank, t, ncm_pkg::FULL_TIME - d, 1'b1);
        end
      end
    endcase
  endfunction

  // Accepted result transaction: compare with the oldest expected segment
  function void check_segment(ncm_pkg::out_item_t got);
    ncm_pkg::out_item_t exp_s;
    if (due_segments.size() == 0) begin
      $error("unexpected segment: tube_code %0d anode %0d on_time %0d last %0d",
             got.tube_code, got.anode, got.on_time, got.last);
      seg_errors++;
      return;
    end
    exp_s = due_segments.pop_front();
    seg_checked++;
    if (got.tube_code !== exp_s.tube_code) begin
      $error("tube_code: expected %0d, got %0d", exp_s.tube_code, got.tube_code);
      seg_errors++;
    end
    if (got.anode !== exp_s.anode) begin
      $error("anode: expected %0d, got %0d", exp_s.anode, got.anode);
      seg_errors++;
    end
    if (got.on_time !== exp_s.on_time) begin
      $error("on_time: expected %0d, got %0d", exp_s.on_time, got.on_time);
      seg_errors++;
    end
    if (got.last !== exp_s.last) begin
      $error("last: expected %0d, got %0d", exp_s.last, got.last);
      seg_errors++;
    end
  endfunction
endclass

module nixie_crossfade_multiplexer_core_test;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_ITEMS  = 300;
  localparam int unsigned SETTLE_TICKS = 8;

  logic               clk_i;
  logic               rst_ni      = 1'b1;
  logic               push        = 1'b0;
  ncm_pkg::in_item_t  in_item_i   = '0;
  logic               full;
  logic               empty;
  logic               pop         = 1'b0;
  ncm_pkg::out_item_t out_item_o;
  logic               cfg_we_i    = 1'b0;
  logic [3:0]         cfg_wdata_i = 4'd0;

  segment_board sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_writes       = 0;
  int unsigned n_slots        = 0;
  int unsigned cycles         = 0;

  nixie_crossfade_multiplexer_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_item_i   (in_item_i),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on a cycle counter
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Result side: pop chosen at the falling edge, transaction taken at the rising
  initial begin
    forever begin
      @(negedge clk_i);
      pop = ($urandom_range(0, 99) >= recv_stall_pct);
      @(posedge clk_i);
      if (pop && !empty) sb.check_segment(out_item_o);
    end
  end

  // Offer one transaction, with random idle cycles ahead of it
  task automatic send_item(ncm_pkg::in_item_t it);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push      = 1'b1;
    in_item_i = it;
    do begin
      @(posedge clk_i);
      taken = !full;
      if (taken) begin
        sb.note_item(it);
        if (it.operation == ncm_pkg::OP_WRITE) n_writes++;
        else n_slots++;
      end
      @(negedge clk_i);
    end while (!taken);
  endtask

  // Stop sending until every expected segment is back, then let it settle
  task automatic drain_block(int unsigned settle);
    push = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_blank(logic [3:0] code);
    drain_block(SETTLE_TICKS);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = code;
    @(posedge clk_i);
    sb.blank = code;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic ncm_pkg::in_item_t build_item(logic op, logic [2:0] dg,
                                                   logic [4:0] val);
    ncm_pkg::in_item_t it;
    it.operation = op;
    it.digit     = dg;
    it.value     = val;
    return it;
  endfunction

  // Mostly slots so fades run to completion; writes rarely ask to flash
  function automatic ncm_pkg::in_item_t random_item();
    logic [2:0] dg;
    logic [4:0] val;
    if ($urandom_range(0, 99) < 80)
      return build_item(ncm_pkg::OP_SLOT, 3'($urandom_range(0, 7)),
                        5'($urandom_range(0, 31)));
    dg  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                      : 3'($urandom_range(0, 5));
    val = {($urandom_range(0, 9) == 0), 4'($urandom_range(0, 15))};
    return build_item(ncm_pkg::OP_WRITE, dg, val);
  endfunction

  // Main sequence
  initial begin
    logic [3:0] phase_blank [4];
    int unsigned idle_set  [4];
    int unsigned stall_set [4];

    phase_blank = '{4'd0, 4'd15, 4'($urandom_range(1, 14)), 4'($urandom_range(0, 15))};
    idle_set    = '{0, 76, 0, 10};
    stall_set   = '{0, 0, 76, 10};

    // reset goes low just after time zero so the falling edge is seen
    #1 rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: digit extremes, out-of-range digits, flash and plain values
    send_item(build_item(ncm_pkg::OP_WRITE, 3'd0, 5'h00));
    send_item(build_item(ncm_pkg::OP_WRITE, 3'd5, 5'h1F));
    send_item(build_item(ncm_pkg::OP_WRITE, 3'd6, 5'h0A));
    send_item(build_item(ncm_pkg::OP_WRITE, 3'd7, 5'h15));
    send_item(build_item(ncm_pkg::OP_WRITE, 3'd2, 5'h10));
    send_item(build_item(ncm_pkg::OP_WRITE, 3'd3, 5'h0F));
    send_item(build_item(ncm_pkg::OP_WRITE, 3'd1, 5'h09));
    send_item(build_item(ncm_pkg::OP_WRITE, 3'd4, 5'h1A));
    // two rotations: first starts the fades, second shows fading segments
    for (int i = 0; i < 12; i++)
      send_item(build_item(ncm_pkg::OP_SLOT, 3'(i), (i % 2) ? 5'h1F : 5'h00));

    // Random phases, each with its own blank code and handshake pattern
    for (int ph = 0; ph < 4; ph++) begin
      write_blank(phase_blank[ph]);
      send_idle_pct  = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) drain_block(0);
        send_item(random_item());
      end
    end

    drain_block(SETTLE_TICKS);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d writes and %0d slots; checked %0d segments", n_writes,
             n_slots, sb.seg_checked);
    $display("Covered four handshake patterns and four blank codes");
    if (sb.seg_errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
